@@ design/swp_pkg.sv @@
// shared types and codes for the stack with positional insert and delete
package swp_pkg;

	localparam int WORD_W = 32;
	localparam int POS_W  = 8;
	localparam int CNT_W  = 8;
	localparam int FANIN  = 8;

	typedef enum logic [1:0] {
		FUNC_PUSH   = 2'd0,
		FUNC_POP    = 2'd1,
		FUNC_INSERT = 2'd2,
		FUNC_DELETE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_INS  = 2'd1,
		CELL_DEL  = 2'd2
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t         mode;
		logic [WORD_W-1:0]  value;
	} cell_ctrl_t;

endpackage

@@ design/swp_cell.sv @@
// one storage cell of the chain: holds one entry and shifts with its neighbors
module swp_cell
	import swp_pkg::*;
#(
	parameter int IDX_W = 7,
	parameter int IDX   = 0
) (
	input  logic              clk,
	input  cell_ctrl_t        ctrl,
	input  logic [IDX_W-1:0]  slot,
	input  logic [WORD_W-1:0] prev_entry,
	input  logic [WORD_W-1:0] next_entry,
	output logic [WORD_W-1:0] entry,
	output logic [WORD_W-1:0] leaf
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [WORD_W-1:0] entry_q;
	logic              above;
	logic              hit;

	assign above = MY_IDX > slot;
	assign hit   = MY_IDX == slot;

	always_ff @(posedge clk) begin
		unique case (ctrl.mode)
			CELL_INS: begin
				if (above) begin
					entry_q <= prev_entry;
				end else if (hit) begin
					entry_q <= ctrl.value;
				end
			end
			CELL_DEL: begin
				if (above || hit) begin
					entry_q <= next_entry;
				end
			end
			default: ;
		endcase
	end

	// the cell being removed drives its old word into the readout tree
	assign leaf  = (ctrl.mode == CELL_DEL && hit) ? entry_q : '0;
	assign entry = entry_q;

endmodule

@@ design/swp_or_tree.sv @@
// registered eight-way or-tree that gathers the removed word from the cells
module swp_or_tree
	import swp_pkg::*;
#(
	parameter int LEAVES = 128,
	parameter int LEVELS = 3
) (
	input  logic              clk,
	input  logic [WORD_W-1:0] leaf [LEAVES],
	output logic [WORD_W-1:0] result
);

	localparam int PADDED = FANIN ** LEVELS;
	localparam int GROUPS = PADDED / FANIN;

	logic [WORD_W-1:0] leaf_pad [PADDED];
	logic [WORD_W-1:0] node_q   [LEVELS][GROUPS];

	for (genvar i = 0; i < PADDED; i++) begin : g_pad
		if (i < LEAVES) begin : g_used
			assign leaf_pad[i] = leaf[i];
		end else begin : g_zero
			assign leaf_pad[i] = '0;
		end
	end

	for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
		for (genvar j = 0; j < FANIN ** (LEVELS - 1 - k); j++) begin : g_node
			logic [WORD_W-1:0] acc;
			always_comb begin
				acc = '0;
				for (int c = 0; c < FANIN; c++) begin
					if (k == 0) begin
						acc = acc | leaf_pad[j * FANIN + c];
					end else begin
						acc = acc | node_q[(k == 0) ? 0 : k - 1][j * FANIN + c];
					end
				end
			end
			always_ff @(posedge clk) begin
				node_q[k][j] <= acc;
			end
		end
	end

	assign result = node_q[LEVELS-1][0];

endmodule

@@ design/stack_with_positional_insert_delete.sv @@
// top level: stack of signed words with push, pop and positional insert/delete
//
//   port group   dir   tdata (low bit up)               tuser
//   s_*          in    value[31:0], position[39:32]      func[1:0]
//   m_*          out   removed_value[31:0], count[39:32] status[1:0]
//
// one item at a time, LEVELS = ceil(log8(DEPTH)) (LEVELS is 3 at the default
// depth of 128): at the accepting edge the cell row shifts and the removed
// word is captured in the first level of the registered or-tree; it then
// climbs one level per cycle before it lands in the output register.
// arst_n clears the entry count and the handshake state; cell contents are
// not reset and are only read below the count.
// s_tready is low while an item is in the tree or a result is waiting and
// not being taken; a stalled result holds in the output register.
module stack_with_positional_insert_delete
	import swp_pkg::*;
#(
	parameter int DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // value[31:0], position[39:32]
	input  logic [1:0]  s_tuser,   // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // removed_value[31:0], count[39:32]
	output logic [1:0]  m_tuser    // status[1:0]
);

	localparam int IW     = $clog2(DEPTH);
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int WW     = ((CW > POS_W) ? CW : POS_W) + 1;
	localparam int LEVELS = ($clog2(DEPTH) + 2) / 3;

	// input item fields
	logic [WORD_W-1:0] in_value;
	logic [POS_W-1:0]  in_pos;
	func_t             in_func;

	// control state
	logic [CW-1:0]     count_q;
	logic [LEVELS-1:0] vld_s;
	status_t           stat_q;
	logic              out_vld_q;
	logic [WORD_W-1:0] out_removed_q;
	status_t           out_stat_q;
	logic [CNT_W-1:0]  out_cnt_q;

	// per-item decode
	logic              accept;
	logic [WW-1:0]     pos_w;
	logic [WW-1:0]     n_w;
	logic [WW-1:0]     ins_lo;
	logic [WW-1:0]     ins_p;
	logic [WW-1:0]     del_p;
	logic [IW-1:0]     slot;
	cell_ctrl_t        ctrl;
	status_t           status_d;
	logic [CW-1:0]     count_d;
	logic              full;
	logic              empty;

	// chain wiring
	logic [WORD_W-1:0] entry [DEPTH];
	logic [WORD_W-1:0] leaf  [DEPTH];
	logic [WORD_W-1:0] tree_out;

	assign in_value = s_tdata[31:0];
	assign in_pos   = s_tdata[39:32];
	assign in_func  = func_t'(s_tuser);

	// one item at a time: tree empty and output slot free or draining
	assign s_tready = (vld_s == '0) && (!out_vld_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	assign full  = count_q == CW'(DEPTH);
	assign empty = count_q == '0;

	// position clamping for insert (1..n+1) and delete (..n)
	assign pos_w  = WW'(in_pos);
	assign n_w    = WW'(count_q);
	assign ins_lo = (pos_w == '0) ? WW'(1) : pos_w;
	assign ins_p  = (ins_lo > n_w + WW'(1)) ? n_w + WW'(1) : ins_lo;
	assign del_p  = (pos_w > n_w) ? n_w : pos_w;

	always_comb begin
		ctrl.mode  = CELL_HOLD;
		ctrl.value = in_value;
		slot       = '0;
		status_d   = ST_OK;
		count_d    = count_q;
		unique case (in_func)
			FUNC_PUSH, FUNC_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ctrl.mode = accept ? CELL_INS : CELL_HOLD;
					// push is an insert just above the top entry
					slot      = (in_func == FUNC_PUSH) ? IW'(count_q)
						: IW'(ins_p - WW'(1));
					count_d   = count_q + CW'(1);
				end
			end
			FUNC_POP, FUNC_DELETE: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else if (in_func == FUNC_DELETE && in_pos == '0) begin
					status_d = ST_BADPOS;
				end else begin
					ctrl.mode = accept ? CELL_DEL : CELL_HOLD;
					// pop removes the top entry
					slot      = (in_func == FUNC_POP) ? IW'(count_q - CW'(1))
						: IW'(del_p - WW'(1));
					count_d   = count_q - CW'(1);
				end
			end
			default: ;
		endcase
	end

	// the row of cells; each sees its lower and upper neighbor
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] prev_e;
		logic [WORD_W-1:0] next_e;
		if (i == 0) begin : g_bot
			assign prev_e = '0;
		end else begin : g_mid_lo
			assign prev_e = entry[i-1];
		end
		if (i == DEPTH - 1) begin : g_top
			assign next_e = entry[i];
		end else begin : g_mid_hi
			assign next_e = entry[i+1];
		end
		swp_cell #(
			.IDX_W (IW),
			.IDX   (i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.slot       (slot),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.entry      (entry[i]),
			.leaf       (leaf[i])
		);
	end

	// removed word readout, zero unless a cell was taken out
	swp_or_tree #(
		.LEAVES (DEPTH),
		.LEVELS (LEVELS)
	) u_tree (
		.clk    (clk),
		.leaf   (leaf),
		.result (tree_out)
	);

	// count, in-flight marker and pending status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			vld_s   <= '0;
			stat_q  <= ST_OK;
		end else begin
			// in-flight marker walks up with the tree levels
			vld_s <= LEVELS'({vld_s, accept});
			if (accept) begin
				count_q <= count_d;
				stat_q  <= status_d;
			end
		end
	end

	// output register, loaded when the tree finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (vld_s[LEVELS-1]) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s[LEVELS-1]) begin
			out_removed_q <= tree_out;
			out_stat_q    <= stat_q;
			out_cnt_q     <= CNT_W'(count_q);
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_cnt_q, out_removed_q};
	assign m_tuser  = out_stat_q;

endmodule
